// ===== design/wsf_pkg.sv =====
// Shared types, constants and codes of the weighted sensor fusion block.
package wsf_pkg;

    localparam int MAX_SENSORS = 16;
    localparam int IDX_W       = $clog2(MAX_SENSORS);
    localparam int CNT_W       = $clog2(MAX_SENSORS + 1);

    // Accumulator widths: corrected value 33 bits, fused weight 24 bits.
    localparam int CORR_W = 33;
    localparam int WGT_W  = 24;
    localparam int PROD_W = CORR_W + 13;
    localparam int VSUM_W = CORR_W + WGT_W + CNT_W;
    localparam int WSUM_W = WGT_W + CNT_W;
    localparam int CSUM_W = 16 + CNT_W;
    localparam int SUM_W  = CORR_W + CNT_W;

    // Shared divider and square root unit widths.
    localparam int DVD_W  = 64;
    localparam int DVS_W  = 33;
    localparam int ROOT_W = 32;

    localparam logic [16:0] AGREE_ONE = 17'd65536;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_UPDATE,
        OP_DEACT,
        OP_CALIB
    } t_opcode;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIND,
        S_APPLY,
        S_P1A,
        S_P1B,
        S_P1C,
        S_P1D,
        S_VGO,
        S_VWT,
        S_CGO,
        S_CWT,
        S_CHK,
        S_MGO,
        S_MWT,
        S_P2A,
        S_P2B,
        S_P2C,
        S_P2D,
        S_QGO,
        S_QWT,
        S_SGO,
        S_SWT,
        S_RGO,
        S_RWT,
        S_DONE
    } t_state;

    typedef struct packed {
        t_opcode             opcode;
        logic [7:0]          target_id;
        logic signed [31:0]  sample_value;
        logic [15:0]         sample_confidence;
        logic [15:0]         sensor_weight;
        logic signed [31:0]  sensor_bias;
        logic [47:0]         time_stamp;
    } t_in_item;

    typedef struct packed {
        logic                status;
        logic                fused_valid;
        logic signed [31:0]  fused_value;
        logic [15:0]         fused_confidence;
        logic [16:0]         agreement;
        logic [4:0]          fused_count;
        logic [47:0]         latest_time;
    } t_out_item;

endpackage

// ===== design/wsf_div.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
module wsf_div
    import wsf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DVD_W);

    logic [DVS_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_q;
    logic [DVS_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DVS_W:0]    w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_q[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= DVS_W'(w_trial - {1'b0, r_dvs});
            end else begin
                r_rem <= w_trial[DVS_W-1:0];
            end
            r_q <= {r_q[DVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== design/wsf_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module wsf_sqrt
    import wsf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DVD_W-1:0]  i_value,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int STEP_W = $clog2(ROOT_W);
    localparam int REM_W  = ROOT_W + 2;

    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [DVD_W-1:0]  r_v;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W+1:0]  w_t;
    logic [REM_W+1:0]  w_trial;
    logic              w_ge;

    assign w_t     = {r_rem, r_v[DVD_W-1:DVD_W-2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = w_t >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_root <= '0;
            r_v    <= i_value;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem  <= REM_W'(w_t - w_trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_t[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
            r_v <= {r_v[DVD_W-3:0], 2'b00};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== design/weighted_sensor_fusion.sv =====
// Top level: sensor table, sequencer and fusion datapath around shared divide and root units.
//
// Input items arrive on i_in_valid / o_in_ready with the i_in_data payload; every item
// yields exactly one result on o_out_valid / i_out_ready with o_out_data. The threshold
// register is written through i_cfg_we / i_cfg_wdata; the user must write it only while the
// block is idle, which the block itself does not enforce. An item is taken only when the
// sequencer is idle, so one item is in work at a time. The id search walks the table one
// entry per cycle. Add, deactivate, calibrate and rejected items go from the id search to
// the table update and then to the result. An accepted update runs two passes over the table
// (states P1A-P1D and P2A-P2D for each counted sensor, P1A or P2A alone for a skipped one),
// up to five divisions on the shared divider and one root on the root unit; the divider
// and the root unit produce one bit per cycle. Reset clears the table (all sensors inactive,
// none in use), the threshold and both handshakes. A finished result sits in an output
// register; when the receiver stalls the block still takes the next item and stops only
// when a second result is ready.
module weighted_sensor_fusion
    import wsf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    t_state r_state, n_state;

    // Sensor table
    logic [7:0]  r_eid   [MAX_SENSORS];
    logic [31:0] r_eval  [MAX_SENSORS];
    logic [15:0] r_econf [MAX_SENSORS];
    logic [15:0] r_ewgt  [MAX_SENSORS];
    logic [31:0] r_ebias [MAX_SENSORS];
    logic [47:0] r_etime [MAX_SENSORS];
    logic [MAX_SENSORS-1:0] r_act;
    logic [CNT_W-1:0] r_used;
    logic [15:0] r_thr;

    t_in_item  r_item;
    t_out_item r_res;
    t_out_item r_out;
    logic      r_ovalid;

    logic [CNT_W-1:0] r_idx;
    logic             r_found;
    logic [CNT_W-1:0] r_count;

    logic signed [CORR_W-1:0] r_c;
    logic [31:0]              r_wp;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [VSUM_W-1:0] r_vsum;
    logic [WSUM_W-1:0]        r_wsum;
    logic [CSUM_W-1:0]        r_csum;
    logic signed [SUM_W-1:0]  r_sum;
    logic [47:0]              r_latest;
    logic signed [CORR_W:0]   r_mean;
    logic signed [CORR_W+1:0] r_d;
    logic [61:0]              r_sq;
    logic [63:0]              r_var;
    logic [CORR_W-1:0]        r_max;
    logic [ROOT_W-1:0]        r_sd;

    logic [IDX_W-1:0]  w_ix;
    logic              w_at_end;
    logic              w_hit;
    logic              w_counted;
    logic signed [CORR_W-1:0] w_corr;
    logic [CORR_W-1:0] w_cabs;
    logic [CORR_W+1:0] w_dabs;
    logic [30:0]       w_a;
    logic [VSUM_W-1:0] w_vabs;
    logic [SUM_W-1:0]  w_sabs;
    logic [16:0]       w_ratio;

    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic             div_done;
    logic [DVD_W-1:0] div_q;
    logic             sq_start;
    logic             sq_done;
    logic [ROOT_W-1:0] sq_root;

    assign w_ix      = r_idx[IDX_W-1:0];
    assign w_at_end  = r_idx == r_used;
    assign w_hit     = !w_at_end && (r_eid[w_ix] == r_item.target_id);
    assign w_counted = r_act[w_ix] && (r_econf[w_ix] >= r_thr);
    assign w_corr    = CORR_W'($signed(r_eval[w_ix])) + CORR_W'($signed(r_ebias[w_ix]));
    assign w_cabs    = r_c[CORR_W-1] ? CORR_W'(-r_c) : CORR_W'(r_c);
    assign w_dabs    = r_d[CORR_W+1] ? (CORR_W+2)'(-r_d) : (CORR_W+2)'(r_d);
    assign w_a       = w_dabs[34:4];
    assign w_vabs    = r_vsum[VSUM_W-1] ? VSUM_W'(-r_vsum) : VSUM_W'(r_vsum);
    assign w_sabs    = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_ratio   = (div_q > DVD_W'(AGREE_ONE)) ? AGREE_ONE : div_q[16:0];

    wsf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    wsf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_var),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_FIND;
            S_FIND:  if (w_at_end || w_hit) n_state = S_APPLY;
            S_APPLY: begin
                if (r_item.opcode == OP_UPDATE && r_found) n_state = S_P1A;
                else n_state = S_DONE;
            end
            S_P1A: begin
                if (w_at_end) n_state = (r_wsum != '0) ? S_VGO : S_CHK;
                else if (w_counted) n_state = S_P1B;
            end
            S_P1B:   n_state = S_P1C;
            S_P1C:   n_state = S_P1D;
            S_P1D:   n_state = S_P1A;
            S_VGO:   n_state = S_VWT;
            S_VWT:   if (div_done) n_state = S_CGO;
            S_CGO:   n_state = S_CWT;
            S_CWT:   if (div_done) n_state = S_CHK;
            S_CHK:   n_state = (r_count < CNT_W'(2)) ? S_DONE : S_MGO;
            S_MGO:   n_state = S_MWT;
            S_MWT:   if (div_done) n_state = S_P2A;
            S_P2A: begin
                if (w_at_end) n_state = S_QGO;
                else if (w_counted) n_state = S_P2B;
            end
            S_P2B:   n_state = S_P2C;
            S_P2C:   n_state = S_P2D;
            S_P2D:   n_state = S_P2A;
            S_QGO:   n_state = S_QWT;
            S_QWT:   if (div_done) n_state = S_SGO;
            S_SGO:   n_state = S_SWT;
            S_SWT:   if (sq_done) n_state = (r_max == '0) ? S_DONE : S_RGO;
            S_RGO:   n_state = S_RWT;
            S_RWT:   if (div_done) n_state = S_DONE;
            S_DONE:  if (!r_ovalid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs and divider operand selection
    always_comb begin
        o_in_ready = 1'b0;
        div_start  = 1'b0;
        sq_start   = 1'b0;
        div_dvd    = '0;
        div_dvs    = '0;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_VGO: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(w_vabs);
                div_dvs   = DVS_W'(r_wsum);
            end
            S_CGO: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(r_csum);
                div_dvs   = DVS_W'(r_count);
            end
            S_MGO: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(w_sabs);
                div_dvs   = DVS_W'(r_count);
            end
            S_QGO: begin
                div_start = 1'b1;
                div_dvd   = r_var;
                div_dvs   = DVS_W'(r_count);
            end
            S_SGO: sq_start = 1'b1;
            S_RGO: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'({r_sd, 20'b0});
                div_dvs   = DVS_W'(r_max);
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_act    <= '0;
            r_used   <= '0;
            r_thr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_thr <= i_cfg_wdata;
            if (r_state == S_DONE && (!r_ovalid || i_out_ready)) r_ovalid <= 1'b1;
            else if (o_out_valid && i_out_ready) r_ovalid <= 1'b0;
            if (r_state == S_APPLY) begin
                unique case (r_item.opcode)
                    OP_ADD: begin
                        if (r_used != CNT_W'(MAX_SENSORS) && !r_found) begin
                            r_act[r_used[IDX_W-1:0]] <= 1'b1;
                            r_used <= r_used + 1'b1;
                        end
                    end
                    OP_UPDATE: if (r_found) r_act[w_ix] <= 1'b1;
                    OP_DEACT:  if (r_found) r_act[w_ix] <= 1'b0;
                    OP_CALIB:  ;
                    default:   ;
                endcase
            end
        end
    end

    // Table contents and fusion datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_item  <= i_in_data;
                    r_res   <= '0;
                    r_idx   <= '0;
                    r_found <= 1'b0;
                end
            end
            S_FIND: begin
                if (w_hit) r_found <= 1'b1;
                else if (!w_at_end) r_idx <= r_idx + 1'b1;
            end
            S_APPLY: begin
                r_idx    <= '0;
                r_count  <= '0;
                r_vsum   <= '0;
                r_wsum   <= '0;
                r_csum   <= '0;
                r_sum    <= '0;
                r_latest <= '0;
                unique case (r_item.opcode)
                    OP_ADD: begin
                        if (r_used == CNT_W'(MAX_SENSORS) || r_found) begin
                            r_res.status <= 1'b1;
                        end else begin
                            r_eid[r_used[IDX_W-1:0]]   <= r_item.target_id;
                            r_eval[r_used[IDX_W-1:0]]  <= '0;
                            r_econf[r_used[IDX_W-1:0]] <= '0;
                            r_ewgt[r_used[IDX_W-1:0]]  <= r_item.sensor_weight;
                            r_ebias[r_used[IDX_W-1:0]] <= r_item.sensor_bias;
                            r_etime[r_used[IDX_W-1:0]] <= '0;
                        end
                    end
                    OP_UPDATE: begin
                        if (!r_found) begin
                            r_res.status <= 1'b1;
                        end else begin
                            r_eval[w_ix]  <= r_item.sample_value;
                            r_econf[w_ix] <= r_item.sample_confidence;
                            r_etime[w_ix] <= r_item.time_stamp;
                            r_res.fused_valid <= 1'b1;
                        end
                    end
                    OP_DEACT: if (!r_found) r_res.status <= 1'b1;
                    OP_CALIB: begin
                        if (!r_found) r_res.status <= 1'b1;
                        else r_ebias[w_ix] <= r_item.sensor_bias;
                    end
                    default: ;
                endcase
            end
            S_P1A: begin
                if (!w_at_end) begin
                    if (w_counted) begin
                        r_c     <= w_corr;
                        r_wp    <= r_ewgt[w_ix] * r_econf[w_ix];
                        r_csum  <= r_csum + CSUM_W'(r_econf[w_ix]);
                        r_count <= r_count + 1'b1;
                        if (r_etime[w_ix] > r_latest) r_latest <= r_etime[w_ix];
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end else begin
                    r_res.fused_count <= 5'(r_count);
                    r_res.latest_time <= r_latest;
                end
            end
            S_P1B: begin
                r_prod <= PROD_W'(r_c) * PROD_W'($signed({1'b0, r_wp[19:8]}));
                r_sum  <= r_sum + SUM_W'(r_c);
            end
            S_P1C: begin
                r_vsum <= r_vsum + VSUM_W'(r_prod);
                r_prod <= PROD_W'(r_c) * PROD_W'($signed({1'b0, r_wp[31:20]}));
                r_wsum <= r_wsum + WSUM_W'(r_wp[31:8]);
            end
            S_P1D: begin
                r_vsum <= r_vsum + (VSUM_W'(r_prod) <<< 12);
                r_idx  <= r_idx + 1'b1;
            end
            S_VWT: begin
                // Quotient magnitude, then sign and clamp to the 32-bit range.
                if (div_done) begin
                    if (!r_vsum[VSUM_W-1]) begin
                        if (div_q > DVD_W'(32'h7FFF_FFFF)) r_res.fused_value <= 32'sh7FFF_FFFF;
                        else r_res.fused_value <= $signed(div_q[31:0]);
                    end else begin
                        if (div_q > DVD_W'(32'h8000_0000)) r_res.fused_value <= 32'sh8000_0000;
                        else r_res.fused_value <= $signed(32'(~div_q[31:0] + 32'd1));
                    end
                end
            end
            S_CWT: if (div_done) r_res.fused_confidence <= div_q[15:0];
            S_CHK: begin
                if (r_count == CNT_W'(1)) r_res.agreement <= AGREE_ONE;
                r_idx <= '0;
                r_var <= '0;
                r_max <= '0;
            end
            S_MWT: begin
                if (div_done) begin
                    if (r_sum[SUM_W-1]) r_mean <= -$signed({1'b0, div_q[CORR_W-1:0]});
                    else r_mean <= $signed({1'b0, div_q[CORR_W-1:0]});
                end
            end
            S_P2A: begin
                if (!w_at_end) begin
                    if (w_counted) r_c <= w_corr;
                    else r_idx <= r_idx + 1'b1;
                end
            end
            S_P2B: begin
                r_d <= (CORR_W+2)'(r_c) - (CORR_W+2)'(r_mean);
                if (w_cabs > r_max) r_max <= w_cabs;
            end
            S_P2C: r_sq <= w_a * w_a;
            S_P2D: begin
                r_var <= r_var + 64'(r_sq);
                r_idx <= r_idx + 1'b1;
            end
            S_QWT: if (div_done) r_var <= div_q;
            S_SWT: begin
                if (sq_done) begin
                    r_sd <= sq_root;
                    if (r_max == '0) r_res.agreement <= AGREE_ONE;
                end
            end
            S_RWT: if (div_done) r_res.agreement <= AGREE_ONE - w_ratio;
            S_DONE: if (!r_ovalid || i_out_ready) r_out <= r_res;
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(MAX_SENSORS))
        else $error("sensor table count beyond its depth");

    a_fused_not_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.fused_valid && o_out_data.status))
        else $error("rejected result carries a fused reading");

    a_empty_fuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.fused_count == 5'd0) |->
            (o_out_data.fused_value == 32'sd0 && o_out_data.latest_time == 48'd0
             && o_out_data.agreement == 17'd0))
        else $error("fusion over no sensor reports data");

    a_agree_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.agreement <= AGREE_ONE)
        else $error("agreement above one");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> !div_done)
        else $error("divider reported done right after start");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the weighted sensor fusion block.
module testbench;
    import wsf_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    weighted_sensor_fusion DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    localparam int LIMIT = 3_000_000;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Shadow copy of the sensor table.
    logic [7:0]         tbl_id     [MAX_SENSORS];
    logic signed [32:0] tbl_value  [MAX_SENSORS];
    logic [15:0]        tbl_conf   [MAX_SENSORS];
    logic [15:0]        tbl_weight [MAX_SENSORS];
    logic signed [32:0] tbl_bias   [MAX_SENSORS];
    logic [47:0]        tbl_time   [MAX_SENSORS];
    logic               tbl_active [MAX_SENSORS];
    int                 tbl_used;
    logic [15:0]        conf_thresh;

    t_out_item pending_results[$];
    int errors, cycles, n_items, n_fused;

    function automatic int find_sensor(logic [7:0] id);
        for (int i = 0; i < tbl_used; i++)
            if (tbl_id[i] == id) return i;
        return -1;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_out_item fuse_table();
        t_out_item r;
        longint wsum, csum, vsum, sum, mean, c, d, w, v;
        logic [63:0] latest, var_acc, maxabs, a, sd, ratio;
        int cnt;
        r = '0;
        wsum = 0; csum = 0; vsum = 0; sum = 0; latest = 0; cnt = 0;
        for (int i = 0; i < tbl_used; i++) begin
            if (!tbl_active[i] || tbl_conf[i] < conf_thresh) continue;
            c = longint'(tbl_value[i]) + longint'(tbl_bias[i]);
            w = (longint'(tbl_weight[i]) * longint'(tbl_conf[i])) >>> 8;
            wsum += w;
            vsum += c * w;
            csum += tbl_conf[i];
            sum += c;
            if (tbl_time[i] > latest) latest = tbl_time[i];
            cnt++;
        end
        if (wsum > 0) begin
            v = vsum / wsum;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            r.fused_value = v[31:0];
            r.fused_confidence = 16'(csum / cnt);
        end
        if (cnt < 2) begin
            r.agreement = (cnt == 1) ? AGREE_ONE : 17'd0;
        end else begin
            mean = sum / cnt;
            var_acc = 0; maxabs = 0;
            for (int i = 0; i < tbl_used; i++) begin
                if (!tbl_active[i] || tbl_conf[i] < conf_thresh) continue;
                c = longint'(tbl_value[i]) + longint'(tbl_bias[i]);
                d = c - mean;
                a = (d < 0 ? -d : d) >> 4;
                var_acc += a * a;
                if ((c < 0 ? -c : c) > maxabs) maxabs = (c < 0 ? -c : c);
            end
            var_acc = var_acc / cnt;
            sd = int_sqrt(var_acc);
            if (maxabs == 0) begin
                r.agreement = AGREE_ONE;
            end else begin
                ratio = (sd << 20) / maxabs;
                if (ratio > 65536) ratio = 65536;
                r.agreement = 17'(65536 - ratio);
            end
        end
        r.fused_valid = 1'b1;
        r.fused_count = 5'(cnt);
        r.latest_time = latest;
        return r;
    endfunction

    // Applies one item to the shadow table and returns the result it should give.
    function automatic t_out_item apply_item(t_in_item it);
        t_out_item r;
        int k;
        r = '0;
        if (it.opcode == OP_ADD) begin
            if (tbl_used >= MAX_SENSORS || find_sensor(it.target_id) >= 0) begin
                r.status = 1'b1;
                return r;
            end
            k = tbl_used;
            tbl_used = tbl_used + 1;
            tbl_id[k] = it.target_id;
            tbl_value[k] = 0;
            tbl_conf[k] = 0;
            tbl_weight[k] = it.sensor_weight;
            tbl_bias[k] = it.sensor_bias;
            tbl_time[k] = 0;
            tbl_active[k] = 1'b1;
            return r;
        end
        k = find_sensor(it.target_id);
        if (k < 0) begin
            r.status = 1'b1;
            return r;
        end
        case (it.opcode)
            OP_UPDATE: begin
                tbl_value[k] = it.sample_value;
                tbl_conf[k] = it.sample_confidence;
                tbl_time[k] = it.time_stamp;
                tbl_active[k] = 1'b1;
                r = fuse_table();
            end
            OP_DEACT: tbl_active[k] = 1'b0;
            default:  tbl_bias[k] = it.sensor_bias;
        endcase
        return r;
    endfunction

    function automatic t_in_item make_item(t_opcode op, logic [7:0] id, int val, int conf,
                                           int wgt, int bias, logic [47:0] ts);
        t_in_item it;
        it.opcode = op;
        it.target_id = id;
        it.sample_value = val;
        it.sample_confidence = conf[15:0];
        it.sensor_weight = wgt[15:0];
        it.sensor_bias = bias;
        it.time_stamp = ts;
        return it;
    endfunction

    function automatic t_in_item rand_item(logic [7:0] id_span);
        t_in_item it;
        int r;
        r = $urandom_range(0, 99);
        it.opcode = r < 15 ? OP_ADD : r < 75 ? OP_UPDATE : r < 87 ? OP_DEACT : OP_CALIB;
        it.target_id = ($urandom_range(0, 19) == 0) ? 8'($urandom) :
                       8'($urandom_range(0, id_span));
        case ($urandom_range(0, 3))
            0:       it.sample_value = $urandom;
            1:       it.sample_value = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: it.sample_value = 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
        it.sample_confidence = $urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom);
        it.sensor_weight = $urandom_range(0, 7) == 0 ? 16'd0 : 16'($urandom);
        it.sensor_bias = $urandom_range(0, 2) == 0 ? 32'($urandom) :
                         32'($signed($urandom_range(0, 200000)) - 100000);
        it.time_stamp = {16'($urandom), 32'($urandom)};
        return it;
    endfunction

    // Receiver: checks each transfer and stalls on its own pattern.
    always @(posedge clk) begin
        t_out_item exp_r;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            cycles <= cycles + 1;
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errors++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (exp_r.status != out_data.status) begin
                        $error("status exp %0d got %0d", exp_r.status, out_data.status);
                        errors++;
                    end
                    if (exp_r.fused_valid != out_data.fused_valid) begin
                        $error("fused_valid exp %0d got %0d", exp_r.fused_valid,
                               out_data.fused_valid);
                        errors++;
                    end
                    if (exp_r.fused_value != out_data.fused_value) begin
                        $error("fused_value exp %0d got %0d", exp_r.fused_value,
                               out_data.fused_value);
                        errors++;
                    end
                    if (exp_r.fused_confidence != out_data.fused_confidence) begin
                        $error("fused_confidence exp %0d got %0d", exp_r.fused_confidence,
                               out_data.fused_confidence);
                        errors++;
                    end
                    if (exp_r.agreement != out_data.agreement) begin
                        $error("agreement exp %0d got %0d", exp_r.agreement,
                               out_data.agreement);
                        errors++;
                    end
                    if (exp_r.fused_count != out_data.fused_count) begin
                        $error("fused_count exp %0d got %0d", exp_r.fused_count,
                               out_data.fused_count);
                        errors++;
                    end
                    if (exp_r.latest_time != out_data.latest_time) begin
                        $error("latest_time exp %0d got %0d", exp_r.latest_time,
                               out_data.latest_time);
                        errors++;
                    end
                    if (exp_r.fused_valid) n_fused++;
                end
            end
            // Long ready stretches alternate with bursts of stalls.
            if (cycles % 2000 < 600) out_ready <= 1'b1;
            else out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk) begin
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("weighted_sensor_fusion verification failed");
            $finish;
        end
    end

    // Drives one item and holds it until the transfer; a row flag of 1 means a typed result.
    task automatic send(t_in_item it, bit typed, t_out_item typed_r);
        t_out_item pr;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pr = apply_item(it);
        if (typed && pr != typed_r) begin
            $error("typed row disagrees with predictor for op %s", it.opcode.name());
            errors++;
        end
        pending_results.push_back(typed ? typed_r : pr);
        n_items++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        // Every result is back, so nothing is in work; leave a short idle gap.
        repeat (2) @(posedge clk);
    endtask

    task automatic write_thresh(logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        conf_thresh = v;
    endtask

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item result;
    } t_row;

    t_row rows[$];

    function automatic t_out_item status_only(logic st);
        t_out_item r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    function automatic t_out_item single_fused(int val, logic [15:0] conf, logic [47:0] ts);
        t_out_item r;
        r = '0;
        r.fused_valid = 1'b1;
        r.fused_value = val;
        r.fused_confidence = conf;
        r.agreement = AGREE_ONE;
        r.fused_count = 5'd1;
        r.latest_time = ts;
        return r;
    endfunction

    initial begin
        logic [7:0] span;
        errors = 0; cycles = 0; n_items = 0; n_fused = 0;
        tbl_used = 0; conf_thresh = 0;
        for (int i = 0; i < MAX_SENSORS; i++) tbl_active[i] = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        rows.push_back('{make_item(OP_UPDATE, 8'd5, 0, 0, 0, 0, 0), 1, status_only(1)});
        rows.push_back('{make_item(OP_DEACT, 8'd5, 0, 0, 0, 0, 0), 1, status_only(1)});
        rows.push_back('{make_item(OP_CALIB, 8'd5, 0, 0, 0, 0, 0), 1, status_only(1)});
        rows.push_back('{make_item(OP_ADD, 8'd0, 0, 0, 16'hffff, 0, 0), 1, status_only(0)});
        rows.push_back('{make_item(OP_ADD, 8'd0, 0, 0, 1, 0, 0), 1, status_only(1)});
        rows.push_back('{make_item(OP_UPDATE, 8'd0, 32'h7fffffff, 16'hffff, 0, 0,
                         48'hffffffffffff), 1, single_fused(32'h7fffffff, 16'hffff,
                         48'hffffffffffff)});
        rows.push_back('{make_item(OP_ADD, 8'd255, 0, 0, 0, 32'h80000000, 0), 1,
                         status_only(0)});
        // Zero weight sensor alongside the first.
        rows.push_back('{make_item(OP_UPDATE, 8'd255, 32'h80000000, 16'hffff, 0, 0, 1), 0,
                         '0});
        rows.push_back('{make_item(OP_CALIB, 8'd0, 0, 0, 0, 32'h7fffffff, 0), 1,
                         status_only(0)});
        rows.push_back('{make_item(OP_UPDATE, 8'd0, 0, 0, 0, 0, 7), 0, '0});
        rows.push_back('{make_item(OP_DEACT, 8'd0, 0, 0, 0, 0, 0), 1, status_only(0)});
        rows.push_back('{make_item(OP_UPDATE, 8'd255, 0, 16'd0, 0, 0, 0), 0, '0});
        rows.push_back('{make_item(OP_CALIB, 8'd255, 0, 0, 0, 0, 0), 1, status_only(0)});
        rows.push_back('{make_item(OP_UPDATE, 8'd0, 0, 16'd1, 0, 0, 3), 0, '0});
        for (int i = 1; i < MAX_SENSORS - 1; i++)
            rows.push_back('{make_item(OP_ADD, 8'(i), 0, 0, 16'h0100, 0, 0), 1,
                             status_only(0)});
        rows.push_back('{make_item(OP_ADD, 8'd200, 0, 0, 0, 0, 0), 1, status_only(1)});
        foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].result);
        drain();

        // Threshold high: nothing passes except full confidence.
        write_thresh(16'hffff);
        send(make_item(OP_UPDATE, 8'd3, 32'd12345, 16'hfffe, 0, 0, 99), 0, '0);
        send(make_item(OP_UPDATE, 8'd4, -32'sd777, 16'hffff, 0, 0, 5), 0, '0);
        drain();

        // Random phases with varying thresholds and table occupancy.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_thresh(16'd0);
                1: write_thresh(16'h8000);
                2: write_thresh(16'($urandom));
                default: write_thresh(16'($urandom_range(0, 16'h4000)));
            endcase
            if (phase >= 3) begin
                // Widen the id range so more items address unknown sensors.
                span = 8'(16 + phase * 8);
            end else begin
                span = 8'd23;
            end
            for (int n = 0; n < 170; n++) begin
                send(rand_item(span), 0, '0);
                if ($urandom_range(0, 4) == 0) begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 30)) @(posedge clk);
                end
            end
            drain();
        end

        $display("covered %0d items, %0d fused results checked, thresholds 0 to 65535",
                 n_items, n_fused);
        if (errors == 0) begin
            $display("weighted_sensor_fusion verification clean");
        end else begin
            $display("weighted_sensor_fusion verification failed");
        end
        $finish;
    end
endmodule
